>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
// Used by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/stsum_pkg.sv
// Shared types and constants for the segment tree range-sum block.
// No dependencies.
`timescale 1ns / 1ps

package stsum_pkg;

    // Fixed field widths
    localparam int LEAF_W  = 10;
    localparam int VALUE_W = 32;
    localparam int RANGE_W = 11;

    // Default leaf count
    localparam int LEAVES_DEF = 1024;

    // Item opcodes
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LEAF,
        ST_UP,
        ST_QLO,
        ST_QHI,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_step;   // zero one node during the post-reset sweep
        logic load;       // capture an accepted item
        logic leaf_step;  // write the leaf, fetch its sibling
        logic up_step;    // write one parent, fetch the next sibling
        logic q_lo_step;  // left edge of one query level
        logic q_hi_step;  // right edge of one query level, then move up
        logic out_load;   // load the result register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;   // sweep is on the last node
        logic in_query;   // offered item is a query
        logic in_bad;     // offered update points beyond the leaves
        logic at_root;    // update walk has reached the root
        logic lo_lt_hi;   // query window not yet empty
    } dp_stat_t;

endpackage

>>> rtl/core/stsum_ifs.sv
// Request and response channel interfaces (valid/ready).
// Depends on stsum_pkg for field widths.
`timescale 1ns / 1ps

interface stsum_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 cmd;
    logic [stsum_pkg::LEAF_W-1:0]         leaf_index;
    logic signed [stsum_pkg::VALUE_W-1:0] new_value;
    logic [stsum_pkg::RANGE_W-1:0]        range_left;
    logic [stsum_pkg::RANGE_W-1:0]        range_right;

    modport source (
        output valid, cmd, leaf_index, new_value, range_left, range_right,
        input  ready
    );
    modport sink (
        input  valid, cmd, leaf_index, new_value, range_left, range_right,
        output ready
    );
endinterface

interface stsum_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [stsum_pkg::VALUE_W-1:0] range_sum;
    logic                                 bad_index;

    modport source (
        output valid, range_sum, bad_index,
        input  ready
    );
    modport sink (
        input  valid, range_sum, bad_index,
        output ready
    );
endinterface

>>> rtl/core/stsum_ctrl.sv
// Sequencing state machine for the segment tree block.
// Depends on stsum_pkg (state_t, dp_cmd_t, dp_stat_t).
`timescale 1ns / 1ps

module stsum_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  stsum_pkg::dp_stat_t stat,
    output stsum_pkg::dp_cmd_t  cmd
);

    stsum_pkg::state_t state_reg, state_next;
    logic              out_valid_reg, out_valid_next;

    // State and result-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stsum_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg & ~rsp_ready;
        cmd            = '0;
        req_ready      = 1'b0;

        unique case (state_reg)
            stsum_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = stsum_pkg::ST_IDLE;
                end
            end

            stsum_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    priority if (stat.in_query)
                    begin
                        state_next = stsum_pkg::ST_QLO;
                    end
                    else if (stat.in_bad)
                    begin
                        state_next = stsum_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = stsum_pkg::ST_LEAF;
                    end
                end
            end

            stsum_pkg::ST_LEAF:
            begin
                cmd.leaf_step = 1'b1;
                state_next    = stsum_pkg::ST_UP;
            end

            stsum_pkg::ST_UP:
            begin
                cmd.up_step = 1'b1;
                if (stat.at_root)
                begin
                    state_next = stsum_pkg::ST_DONE;
                end
            end

            stsum_pkg::ST_QLO:
            begin
                if (stat.lo_lt_hi)
                begin
                    cmd.q_lo_step = 1'b1;
                    state_next    = stsum_pkg::ST_QHI;
                end
                else
                begin
                    state_next = stsum_pkg::ST_DONE;
                end
            end

            stsum_pkg::ST_QHI:
            begin
                cmd.q_hi_step = 1'b1;
                state_next    = stsum_pkg::ST_QLO;
            end

            stsum_pkg::ST_DONE:
            begin
                // wait for the result slot to free up
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = stsum_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = stsum_pkg::ST_CLEAR;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;

endmodule

>>> rtl/core/stsum_dp.sv
// Datapath: node memory, walk indices, accumulator and result register.
// Depends on stsum_pkg (dp_cmd_t, dp_stat_t, widths, opcodes).
`timescale 1ns / 1ps

module stsum_dp #(
    parameter int LEAVES = stsum_pkg::LEAVES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  stsum_pkg::dp_cmd_t                   cmd,
    output stsum_pkg::dp_stat_t                  stat,
    input  logic                                 req_cmd,
    input  logic [stsum_pkg::LEAF_W-1:0]         leaf_index,
    input  logic signed [stsum_pkg::VALUE_W-1:0] new_value,
    input  logic [stsum_pkg::RANGE_W-1:0]        range_left,
    input  logic [stsum_pkg::RANGE_W-1:0]        range_right,
    output logic signed [stsum_pkg::VALUE_W-1:0] range_sum,
    output logic                                 bad_index
);

    localparam int DEPTH  = 2 * LEAVES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = $clog2(DEPTH + 1);
    localparam int EXT_W  = (POS_W > stsum_pkg::RANGE_W) ? POS_W : stsum_pkg::RANGE_W;
    localparam int VW     = stsum_pkg::VALUE_W;

    localparam logic [EXT_W-1:0]  LEAVES_EXT = EXT_W'(LEAVES);
    localparam logic [POS_W-1:0]  LEAVES_POS = POS_W'(LEAVES);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] ROOT_ADDR  = ADDR_W'(1);

    // Node sums, node 1 is the root, leaf i at LEAVES + i
    logic [VW-1:0] node_mem [DEPTH];
    logic [VW-1:0] rdata_reg;

    logic [ADDR_W-1:0] clr_reg;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] k_reg;
    logic [VW-1:0]     val_reg;
    logic [VW-1:0]     cur_reg;
    logic [POS_W-1:0]  lo_reg;
    logic [POS_W-1:0]  hi_reg;
    logic [VW-1:0]     acc_reg;
    logic              query_reg;
    logic              bad_reg;
    logic [VW-1:0]     sum_out_reg;
    logic              bad_out_reg;

    logic [EXT_W-1:0]  leaf_ext, rl_ext, rr_ext, hi_clamp, lo_clamp, leaf_node;
    logic [POS_W-1:0]  lo_start, hi_start, hi_even;
    logic [ADDR_W-1:0] k_sib;
    logic [VW-1:0]     sum_up;
    logic              in_bad;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [VW-1:0]     mem_wdata;

    // Item decode: clamp the range, place it in node space
    always_comb
    begin
        leaf_ext  = EXT_W'(leaf_index);
        rl_ext    = EXT_W'(range_left);
        rr_ext    = EXT_W'(range_right);
        hi_clamp  = (rr_ext > LEAVES_EXT) ? LEAVES_EXT : rr_ext;
        lo_clamp  = (rl_ext >= hi_clamp) ? hi_clamp : rl_ext;
        lo_start  = POS_W'(lo_clamp) + LEAVES_POS;
        hi_start  = POS_W'(hi_clamp) + LEAVES_POS;
        leaf_node = leaf_ext + LEAVES_EXT;
        in_bad    = (leaf_ext >= LEAVES_EXT);
    end

    assign k_sib   = {k_reg[ADDR_W-1:1], ~k_reg[0]};
    assign hi_even = {hi_reg[POS_W-1:1], 1'b0};
    assign sum_up  = cur_reg + rdata_reg;

    // Status back to the controller
    always_comb
    begin
        stat.clr_last = (clr_reg == LAST_ADDR);
        stat.in_query = (req_cmd == stsum_pkg::CMD_QUERY);
        stat.in_bad   = in_bad;
        stat.at_root  = (k_reg == ROOT_ADDR);
        stat.lo_lt_hi = (lo_reg < hi_reg);
    end

    // Memory port steering
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = k_sib;
        priority if (cmd.clr_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.leaf_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = k_reg;
            mem_wdata = val_reg;
            mem_re    = 1'b1;
        end
        else if (cmd.up_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = k_reg;
            mem_wdata = sum_up;
            mem_re    = (k_reg != ROOT_ADDR);
        end
        else if (cmd.q_lo_step)
        begin
            mem_re    = lo_reg[0];
            mem_raddr = lo_reg[ADDR_W-1:0];
        end
        else if (cmd.q_hi_step)
        begin
            mem_re    = hi_reg[0];
            mem_raddr = hi_even[ADDR_W-1:0];
        end
    end

    // a query read issued now is added to the sum next cycle
    assign pend_next = (cmd.q_lo_step & lo_reg[0]) | (cmd.q_hi_step & hi_reg[0]);

    // Node memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= node_mem[mem_raddr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            pend_reg <= pend_next;
        end
    end

    // Walk registers and accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            query_reg <= (req_cmd == stsum_pkg::CMD_QUERY);
            bad_reg   <= (req_cmd == stsum_pkg::CMD_UPDATE) && in_bad;
            val_reg   <= new_value;
            k_reg     <= leaf_node[ADDR_W-1:0];
            lo_reg    <= lo_start;
            hi_reg    <= hi_start;
            acc_reg   <= '0;
        end
        else
        begin
            if (pend_reg)
            begin
                acc_reg <= acc_reg + rdata_reg;
            end
            if (cmd.leaf_step)
            begin
                cur_reg <= val_reg;
                k_reg   <= k_reg >> 1;
            end
            if (cmd.up_step)
            begin
                cur_reg <= sum_up;
                k_reg   <= k_reg >> 1;
            end
            if (cmd.q_lo_step && lo_reg[0])
            begin
                lo_reg <= lo_reg + POS_W'(1);
            end
            if (cmd.q_hi_step)
            begin
                lo_reg <= lo_reg >> 1;
                hi_reg <= hi_reg >> 1;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            sum_out_reg <= query_reg ? acc_reg : '0;
            bad_out_reg <= bad_reg;
        end
    end

    assign range_sum = sum_out_reg;
    assign bad_index = bad_out_reg;

endmodule

>>> rtl/core/segment_tree_range_sum.sv
// Channel   | Dir | Fields
// ----------+-----+-----------------------------------------------------
// req       | in  | cmd, leaf_index, new_value, range_left, range_right
// rsp       | out | range_sum, bad_index
//
// One item at a time over a node memory with one write and one read port.
// Update: writes the leaf, then one tree level per cycle on the path to the root.
// Query: two read slots per level, left edge then right edge.
// After reset all 2 * LEAVES nodes of the node memory are zeroed; req.ready low.
// A finished result waits in the rsp register while the next item is taken.
//
// Top level: segment tree point update / range sum.
// Depends on stsum_pkg, stsum_ifs, stsum_ctrl, stsum_dp, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module segment_tree_range_sum #(
    parameter int LEAVES = stsum_pkg::LEAVES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    stsum_req_if.sink          req,
    stsum_rsp_if.source        rsp
);

    stsum_pkg::dp_cmd_t  cmd;
    stsum_pkg::dp_stat_t stat;

    logic       req_xfer;
    logic       rsp_flagged;
    logic       rsp_zero;
    logic [5:0] step_vec;

    // Controller
    stsum_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath
    stsum_dp #(
        .LEAVES (LEAVES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_cmd     (req.cmd),
        .leaf_index  (req.leaf_index),
        .new_value   (req.new_value),
        .range_left  (req.range_left),
        .range_right (req.range_right),
        .range_sum   (rsp.range_sum),
        .bad_index   (rsp.bad_index)
    );

    // Terms used by the checks
    assign req_xfer    = req.valid && req.ready;
    assign rsp_flagged = rsp.valid && rsp.bad_index;
    assign rsp_zero    = (rsp.range_sum == '0);
    assign step_vec    = {cmd.clr_step, cmd.load, cmd.leaf_step,
                          cmd.up_step, cmd.q_lo_step, cmd.q_hi_step};

    // Checks
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_xfer, !req.ready, "item taken while busy")
    `ASSERT_ALWAYS(a_single_step, clk, rst_n, $onehot0(step_vec), "conflicting datapath steps")
    `ASSERT_IMPLY(a_clear_blocks, clk, rst_n, cmd.clr_step, !req.ready, "item taken in clear")
    `ASSERT_IMPLY(a_bad_zero, clk, rst_n, rsp_flagged, rsp_zero, "flagged update with sum")

endmodule
